// File: rtl/nsl_pkg.sv
// -----------------------------------------------------------------------------
// nsl_pkg
// Shared types and constants of the nearest seed labeler.
// -----------------------------------------------------------------------------
package nsl_pkg;

   // Width of the ASCII label and the letter of seed zero.
   localparam int unsigned LABEL_W     = 7;
   localparam logic [6:0]  LETTER_BASE = 7'd65;

   // Control bits that ride with every item down the seed chain.
   typedef struct packed {
      logic valid;
      logic is_query;
   } ctl_type;

endpackage

// File: rtl/nsl_req_if.sv
// -----------------------------------------------------------------------------
// nsl_req_if
// Request channel: seed loads and pixel queries, valid/ready handshake.
// -----------------------------------------------------------------------------
interface nsl_req_if #(
   parameter int unsigned IDX_W      = 4,
   parameter int unsigned COORD_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [IDX_W-1:0]      seed_slot;
   logic [COORD_BITS-1:0] x_coord;
   logic [COORD_BITS-1:0] y_coord;

   modport source (output valid, output req_type, output seed_slot,
                   output x_coord, output y_coord, input ready);
   modport sink   (input valid, input req_type, input seed_slot,
                   input x_coord, input y_coord, output ready);
endinterface

// File: rtl/nsl_rsp_if.sv
// -----------------------------------------------------------------------------
// nsl_rsp_if
// Response channel: nearest seed index, label and squared distance.
// -----------------------------------------------------------------------------
interface nsl_rsp_if #(
   parameter int unsigned IDX_W  = 4,
   parameter int unsigned DIST_W = 21
);
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  nearest_index;
   logic [6:0]        label_char;
   logic [DIST_W-1:0] squared_distance;

   modport source (output valid, output nearest_index, output label_char,
                   output squared_distance, input ready);
   modport sink   (input valid, input nearest_index, input label_char,
                   input squared_distance, output ready);
endinterface

// File: rtl/nsl_cell.sv
// -----------------------------------------------------------------------------
// nsl_cell
// One seed of the chain. Holds a seed coordinate, captures loads addressed to
// its slot and folds its distance into the running best of passing queries.
// Two register stages: squares, then sum and compare.
// -----------------------------------------------------------------------------
module nsl_cell #(
   parameter int unsigned INDEX      = 0,
   parameter int unsigned IDX_W      = 4,
   parameter int unsigned COORD_BITS = 10,
   parameter int unsigned CNT_W      = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic [CNT_W-1:0]        count,
   input  nsl_pkg::ctl_type        in_ctl,
   input  logic [IDX_W-1:0]        in_slot,
   input  logic [COORD_BITS-1:0]   in_x,
   input  logic [COORD_BITS-1:0]   in_y,
   input  logic [IDX_W-1:0]        in_best_idx,
   input  logic [2*COORD_BITS:0]   in_best_dist,
   output nsl_pkg::ctl_type        out_ctl,
   output logic [IDX_W-1:0]        out_slot,
   output logic [COORD_BITS-1:0]   out_x,
   output logic [COORD_BITS-1:0]   out_y,
   output logic [IDX_W-1:0]        out_best_idx,
   output logic [2*COORD_BITS:0]   out_best_dist
);
   import nsl_pkg::*;

   localparam int unsigned      SQ_W    = 2 * COORD_BITS;
   localparam int unsigned      DIST_W  = SQ_W + 1;
   localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(INDEX);

   logic [COORD_BITS-1:0] seed_x_ff, seed_y_ff;

   ctl_type               s1_ctl_ff;
   logic [IDX_W-1:0]      s1_slot_ff, s1_idx_ff;
   logic [COORD_BITS-1:0] s1_x_ff, s1_y_ff;
   logic [DIST_W-1:0]     s1_dist_ff;
   logic [SQ_W-1:0]       dx2_ff, dy2_ff;

   ctl_type               s2_ctl_ff;
   logic [IDX_W-1:0]      s2_slot_ff, s2_idx_ff;
   logic [COORD_BITS-1:0] s2_x_ff, s2_y_ff;
   logic [DIST_W-1:0]     s2_dist_ff;

   logic [COORD_BITS-1:0] dx, dy;
   logic [DIST_W-1:0]     dist_sum;
   logic                  take;
   logic                  load_hit;

   assign load_hit = in_ctl.valid && !in_ctl.is_query && (in_slot == MY_SLOT);
   assign dx = (in_x >= seed_x_ff) ? (in_x - seed_x_ff) : (seed_x_ff - in_x);
   assign dy = (in_y >= seed_y_ff) ? (in_y - seed_y_ff) : (seed_y_ff - in_y);

   assign dist_sum = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   // Strict compare keeps the lower index on a tie.
   assign take = (MY_POS < count) && (dist_sum < s1_dist_ff);

   // Seed table entry: no reset, undefined until loaded.
   always_ff @(posedge clock) begin
      if (adv && load_hit) begin
         seed_x_ff <= in_x;
         seed_y_ff <= in_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
      end else if (adv) begin
         s1_ctl_ff <= in_ctl;
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_slot_ff <= in_slot;
         s1_x_ff    <= in_x;
         s1_y_ff    <= in_y;
         s1_idx_ff  <= in_best_idx;
         s1_dist_ff <= in_best_dist;
         dx2_ff     <= {{COORD_BITS{1'b0}}, dx} * {{COORD_BITS{1'b0}}, dx};
         dy2_ff     <= {{COORD_BITS{1'b0}}, dy} * {{COORD_BITS{1'b0}}, dy};
         s2_slot_ff <= s1_slot_ff;
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_idx_ff  <= take ? MY_SLOT : s1_idx_ff;
         s2_dist_ff <= take ? dist_sum : s1_dist_ff;
      end
   end

   assign out_ctl       = s2_ctl_ff;
   assign out_slot      = s2_slot_ff;
   assign out_x         = s2_x_ff;
   assign out_y         = s2_y_ff;
   assign out_best_idx  = s2_idx_ff;
   assign out_best_dist = s2_dist_ff;

endmodule

// File: rtl/nearest_seed_labeler.sv
// -----------------------------------------------------------------------------
// nearest_seed_labeler
// Voronoi labeler: a chain of seed cells that returns the nearest seed of a
// pixel by exact squared Euclidean distance, lowest index on a tie.
//
//   port      | dir | handshake       | carries
//   ----------+-----+-----------------+------------------------------------
//   req_ch    | in  | valid / ready   | req_type, seed_slot, x_coord, y_coord
//   rsp_ch    | out | valid / ready   | nearest_index, label_char, distance
//   csr_*     | in  | csr_wr_en       | num_seeds
//
// One item is taken every cycle while the response side keeps up. A query
// passes two register stages per seed cell before it is written into the
// output register, from which it leaves when the response side takes it.
// Loads travel the same chain, so queries see exactly the seeds loaded before.
// Reset clears the chain's valid bits and sets num_seeds to 1; seeds are not
// cleared. A stalled response freezes the whole chain and drops req ready.
// -----------------------------------------------------------------------------
module nearest_seed_labeler #(
   parameter int unsigned MAX_SEEDS  = 16,
   parameter int unsigned COORD_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   nsl_req_if.sink                               req_ch,
   nsl_rsp_if.source                             rsp_ch,
   input  logic                                  csr_wr_en,
   input  logic [$clog2(MAX_SEEDS+1)-1:0]        csr_wr_data
);
   import nsl_pkg::*;

   localparam int unsigned IDX_W  = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
   localparam int unsigned CNT_W  = $clog2(MAX_SEEDS + 1);
   localparam int unsigned DIST_W = 2 * COORD_BITS + 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEEDS);

   logic [CNT_W-1:0] num_seeds_ff;
   logic [CNT_W-1:0] eff_count;
   logic             adv;

   ctl_type               ctl_c  [0:MAX_SEEDS];
   logic [IDX_W-1:0]      slot_c [0:MAX_SEEDS];
   logic [COORD_BITS-1:0] x_c    [0:MAX_SEEDS];
   logic [COORD_BITS-1:0] y_c    [0:MAX_SEEDS];
   logic [IDX_W-1:0]      idx_c  [0:MAX_SEEDS];
   logic [DIST_W-1:0]     dist_c [0:MAX_SEEDS];

   logic              out_vld_ff;
   logic [IDX_W-1:0]  out_idx_ff;
   logic [DIST_W-1:0] out_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_seeds_ff <= CNT_W'(1);
      end else if (csr_wr_en) begin
         num_seeds_ff <= csr_wr_data;
      end
   end

   // Saturate the seed count into 1..MAX_SEEDS.
   always_comb begin
      eff_count = num_seeds_ff;
      if (num_seeds_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (num_seeds_ff > MAX_CNT) begin
         eff_count = MAX_CNT;
      end
   end

   // Advance the chain unless a finished result is still waiting.
   assign adv          = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   assign ctl_c[0].valid    = req_ch.valid;
   assign ctl_c[0].is_query = req_ch.req_type;
   assign slot_c[0]         = req_ch.seed_slot;
   assign x_c[0]            = req_ch.x_coord;
   assign y_c[0]            = req_ch.y_coord;
   assign idx_c[0]          = '0;
   assign dist_c[0]         = '1;

   for (genvar g = 0; g < MAX_SEEDS; g++) begin : g_cell
      nsl_cell #(
         .INDEX      (g),
         .IDX_W      (IDX_W),
         .COORD_BITS (COORD_BITS),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .adv           (adv),
         .count         (eff_count),
         .in_ctl        (ctl_c[g]),
         .in_slot       (slot_c[g]),
         .in_x          (x_c[g]),
         .in_y          (y_c[g]),
         .in_best_idx   (idx_c[g]),
         .in_best_dist  (dist_c[g]),
         .out_ctl       (ctl_c[g+1]),
         .out_slot      (slot_c[g+1]),
         .out_x         (x_c[g+1]),
         .out_y         (y_c[g+1]),
         .out_best_idx  (idx_c[g+1]),
         .out_best_dist (dist_c[g+1])
      );
   end

   // Output register: only queries leave the chain as responses.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= ctl_c[MAX_SEEDS].valid && ctl_c[MAX_SEEDS].is_query;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_idx_ff  <= idx_c[MAX_SEEDS];
         out_dist_ff <= dist_c[MAX_SEEDS];
      end
   end

   assign rsp_ch.valid            = out_vld_ff;
   assign rsp_ch.nearest_index    = out_idx_ff;
   assign rsp_ch.label_char       = LETTER_BASE + LABEL_W'(out_idx_ff);
   assign rsp_ch.squared_distance = out_dist_ff;

endmodule

// File: rtl/nsl_checker.sv
// -----------------------------------------------------------------------------
// nsl_checker
// Port-level checks of the nearest seed labeler, bound to the top level.
// -----------------------------------------------------------------------------
module nsl_checker #(
   parameter int unsigned IDX_W  = 4,
   parameter int unsigned DIST_W = 21
) (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [IDX_W-1:0]  rsp_index,
   input logic [6:0]        rsp_label,
   input logic [DIST_W-1:0] rsp_dist
);
   import nsl_pkg::*;

   // Hold a stalled response.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_index) && $stable(rsp_dist)))
      else $error("stalled response changed");

   // No response is pending, so the chain must take a request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with no pending response");

   // A stalled response backs up into the request side.
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while response stalled");

   // Label follows the index.
   a_label: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_label == LETTER_BASE + LABEL_W'(rsp_index)))
      else $error("label does not match index");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind nearest_seed_labeler nsl_checker #(
   .IDX_W  (IDX_W),
   .DIST_W (DIST_W)
) u_nsl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_index (rsp_ch.nearest_index),
   .rsp_label (rsp_ch.label_char),
   .rsp_dist  (rsp_ch.squared_distance)
);

// File: tb/sv/tb_nearest_seed_labeler.sv
// -----------------------------------------------------------------------------
// tb_nearest_seed_labeler
// Self-checking bench for the Voronoi seed labeler. Seed loads and pixel
// queries are driven through the request channel. A local predictor keeps its
// own seed table and seed count, and it computes the nearest seed for every
// accepted query. Results are checked in order against the predicted labels,
// under random idle cycles, a long response stall, and full-rate streaming.
// -----------------------------------------------------------------------------
module tb_nearest_seed_labeler;
   timeunit 1ns;
   timeprecision 1ps;

   import nsl_pkg::*;

   localparam int unsigned MAX_SEEDS     = 16;
   localparam int unsigned COORD_BITS    = 10;
   localparam int unsigned CHAIN_LATENCY = 2 * MAX_SEEDS + 1;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam logic        REQ_LOAD      = 1'b0;
   localparam logic        REQ_QUERY     = 1'b1;

   typedef struct packed {
      logic [3:0]  index;
      logic [6:0]  letter;
      logic [20:0] dist_sq;
   } pixel_label_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [4:0] csr_wr_data;

   nsl_req_if #(.IDX_W(4), .COORD_BITS(COORD_BITS)) req_ch ();
   nsl_rsp_if #(.IDX_W(4), .DIST_W(21))             rsp_ch ();

   nearest_seed_labeler #(
      .MAX_SEEDS  (MAX_SEEDS),
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: seed table, loaded slots and the programmed seed count.
   logic [COORD_BITS-1:0] seed_col [MAX_SEEDS];
   logic [COORD_BITS-1:0] seed_row [MAX_SEEDS];
   logic [MAX_SEEDS-1:0]  seed_loaded;
   logic [4:0]            seed_count_reg;

   pixel_label_type expected_labels[$];
   int unsigned     mismatches;
   int unsigned     cycle_count;
   int unsigned     rsp_hold_cycles;
   bit              idling_on;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d labels outstanding",
                  cycle_count, expected_labels.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response side: long hold when requested, otherwise short random bursts.
   initial begin : rsp_driver
      int unsigned burst;
      burst = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (burst > 0) begin
            rsp_ch.ready <= 1'b0;
            burst--;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            burst = $urandom_range(0, 2);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin : label_checker
      pixel_label_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_labels.size() == 0) begin
            note_mismatch($sformatf("unexpected result: index %0d letter %0d dist %0d",
                                    rsp_ch.nearest_index, rsp_ch.label_char,
                                    rsp_ch.squared_distance));
         end else begin
            want = expected_labels.pop_front();
            if (rsp_ch.nearest_index !== want.index || rsp_ch.label_char !== want.letter ||
                rsp_ch.squared_distance !== want.dist_sq) begin
               note_mismatch($sformatf(
                  "label mismatch: exp idx %0d chr %0d dist %0d, got idx %0d chr %0d dist %0d",
                  want.index, want.letter, want.dist_sq, rsp_ch.nearest_index,
                  rsp_ch.label_char, rsp_ch.squared_distance));
            end
         end
      end
   end

   // Zero seeds counts as one, anything past the table as the whole table.
   function automatic int unsigned searched_seeds();
      if (seed_count_reg == 0) return 1;
      if (seed_count_reg > MAX_SEEDS) return MAX_SEEDS;
      return seed_count_reg;
   endfunction

   function automatic pixel_label_type find_nearest_seed(input logic [COORD_BITS-1:0] px,
                                                         input logic [COORD_BITS-1:0] py);
      int unsigned     best_idx;
      int unsigned     best_dist;
      int unsigned     dx;
      int unsigned     dy;
      int unsigned     d;
      pixel_label_type r;
      best_idx  = 0;
      best_dist = 0;
      for (int unsigned s = 0; s < searched_seeds(); s++) begin
         dx = (seed_col[s] >= px) ? seed_col[s] - px : px - seed_col[s];
         dy = (seed_row[s] >= py) ? seed_row[s] - py : py - seed_row[s];
         d  = dx * dx + dy * dy;
         // strict compare keeps the lowest index on a tie
         if (s == 0 || d < best_dist) begin
            best_dist = d;
            best_idx  = s;
         end
      end
      r.index   = best_idx[3:0];
      r.letter  = LETTER_BASE + best_idx[6:0];
      r.dist_sq = best_dist[20:0];
      return r;
   endfunction

   function automatic bit search_is_defined();
      for (int unsigned s = 0; s < searched_seeds(); s++)
         if (!seed_loaded[s]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [COORD_BITS-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return COORD_BITS'($urandom_range(0, 7));
         default: return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
      endcase
   endfunction

   task automatic send_item(input logic kind, input logic [3:0] slot,
                            input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
      int unsigned gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= kind;
      req_ch.seed_slot <= slot;
      req_ch.x_coord   <= x;
      req_ch.y_coord   <= y;
      do @(posedge clock); while (!req_ch.ready);
      // transfer done: update the table or predict the label
      if (kind == REQ_LOAD) begin
         seed_col[slot]    = x;
         seed_row[slot]    = y;
         seed_loaded[slot] = 1'b1;
      end else begin
         expected_labels.push_back(find_nearest_seed(x, y));
      end
   endtask

   task automatic send_random_item();
      logic kind;
      kind = ($urandom_range(0, 3) == 0) ? REQ_LOAD : REQ_QUERY;
      // never search a slot that was not loaded yet
      if (kind == REQ_QUERY && !search_is_defined()) kind = REQ_LOAD;
      send_item(kind, 4'($urandom_range(0, 15)), rand_coord(), rand_coord());
   endtask

   // Drop valid, let all labels arrive, then let trailing loads leave the chain.
   task automatic wait_until_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_labels.size() != 0) @(posedge clock);
      repeat (CHAIN_LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_seed_count(input logic [4:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      seed_count_reg = value;
   endtask

   // One seed at reset count, corner pixels, then a count of zero.
   task automatic test_single_seed();
      send_item(REQ_LOAD, 4'd0, '0, '0);
      send_item(REQ_QUERY, 4'd9, '0, '0);
      send_item(REQ_QUERY, 4'd0, '1, '1);
      send_item(REQ_LOAD, 4'd0, '1, '1);
      send_item(REQ_QUERY, 4'd0, '0, '0);
      wait_until_idle();
      write_seed_count(5'd0);
      send_item(REQ_QUERY, 4'd15, 10'd512, 10'd700);
      wait_until_idle();
   endtask

   // Full table on a diagonal with a duplicate seed and an equidistant pair.
   task automatic test_full_table_ties();
      for (int unsigned k = 0; k < MAX_SEEDS; k++) begin
         if (k == 4) send_item(REQ_LOAD, 4'd4, 10'd192, 10'd192);
         else        send_item(REQ_LOAD, 4'(k), 10'(k * 64), 10'(k * 64));
      end
      wait_until_idle();
      write_seed_count(5'd16);
      send_item(REQ_QUERY, 4'd0, 10'd192, 10'd192);
      send_item(REQ_QUERY, 4'd0, 10'd352, 10'd352);
      send_item(REQ_QUERY, 4'd0, '1, '1);
      send_item(REQ_QUERY, 4'd0, '0, '0);
      wait_until_idle();
      write_seed_count(5'd31);
      send_item(REQ_QUERY, 4'd0, '1, '0);
      wait_until_idle();
   endtask

   task automatic test_random_traffic();
      logic [4:0] counts [5];
      counts = '{5'd16, 5'd1, 5'd31, 5'd0, 5'($urandom_range(2, 15))};
      foreach (counts[p]) begin
         write_seed_count(counts[p]);
         repeat (250) send_random_item();
         wait_until_idle();
      end
   endtask

   // Hold the response side long enough to fill the chain and stall requests.
   task automatic test_output_stall();
      write_seed_count(5'($urandom_range(1, 16)));
      rsp_hold_cycles = 300;
      repeat (150) send_random_item();
      wait_until_idle();
   endtask

   task automatic test_full_rate();
      idling_on = 1'b0;
      write_seed_count(5'd16);
      repeat (200) send_random_item();
      wait_until_idle();
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = REQ_LOAD;
      req_ch.seed_slot = '0;
      req_ch.x_coord   = '0;
      req_ch.y_coord   = '0;
      seed_loaded      = '0;
      seed_count_reg   = 5'd1;
      mismatches       = 0;
      cycle_count      = 0;
      rsp_hold_cycles  = 0;
      idling_on        = 1'b1;
      foreach (seed_col[k]) begin
         seed_col[k] = '0;
         seed_row[k] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_seed();
      test_full_table_ties();
      test_random_traffic();
      test_output_stall();
      test_full_rate();

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: nearest_seed_labeler.f
rtl/nsl_pkg.sv
rtl/nsl_req_if.sv
rtl/nsl_rsp_if.sv
rtl/nsl_cell.sv
rtl/nearest_seed_labeler.sv
rtl/nsl_checker.sv
tb/sv/tb_nearest_seed_labeler.sv
